@@ src/cgcs_pkg.sv @@
// Package for the curvilinear grid cell search unit: types, constants, codes.
package cgcs_pkg;

    localparam int GRID_N1 = 32;
    localparam int GRID_N2 = 32;
    localparam int GRID_N3 = 32;
    localparam int ITER_RESET = 50;
    localparam int ADDR_W = 15;

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_OUTSIDE  = 2'd1,
        STATUS_NOCONV   = 2'd2,
        STATUS_RESERVED = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_BOX_X_LOW  = 3'd0,
        REG_BOX_X_HIGH = 3'd1,
        REG_BOX_Y_LOW  = 3'd2,
        REG_BOX_Y_HIGH = 3'd3,
        REG_BOX_Z_LOW  = 3'd4,
        REG_BOX_Z_HIGH = 3'd5,
        REG_MAX_ITER   = 3'd6,
        REG_UNUSED     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic               cmd;
        logic [4:0]         pos_i;
        logic [4:0]         pos_j;
        logic [4:0]         pos_k;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] cell_i;
        logic [4:0] cell_j;
        logic [4:0] cell_k;
    } out_item_t;

    // Clamp a signed index sum to 0..n-2.
    function automatic logic [8:0] clamp_idx(input logic signed [10:0] v, input int n);
        logic [8:0] r;
        if (v >= 11'(n - 1))
            r = 9'(n - 2);
        else if (v < 0)
            r = '0;
        else
            r = v[8:0];
        return r;
    endfunction

endpackage

@@ src/curvilinear_grid_cell_search_unit.sv @@
// Top level of the curvilinear grid cell search unit.
// A load transfer writes one node. A lookup runs a sequencer over
// one shared 33x33 multiplier, 128-bit accumulators and one restoring quotient step.
// Points outside the box go from the box check straight to the result. Otherwise one
// iteration makes 4 node reads; per axis it forms 6 products, takes the sign, finds
// 9 quotient bits, each from four partial products and a compare, and closes the axis;
// an update step follows. The quotient is skipped when the dot product or norm is zero.
// A lookup keeps the input stalled until its result transfer completes.
// The three node stores are 32768-entry memories with one registered read port each.
module curvilinear_grid_cell_search_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cgcs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cgcs_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import cgcs_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_BOX   = 13'b0000000000010,
        ST_RDB   = 13'b0000000000100,
        ST_WB    = 13'b0000000001000,
        ST_RDE   = 13'b0000000010000,
        ST_WE    = 13'b0000000100000,
        ST_MUL   = 13'b0000001000000,
        ST_SIGN  = 13'b0000010000000,
        ST_QMUL  = 13'b0000100000000,
        ST_QCMP  = 13'b0001000000000,
        ST_AXEND = 13'b0010000000000,
        ST_UPD   = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // Memories
    logic [31:0] mem_x [1<<ADDR_W];
    logic [31:0] mem_y [1<<ADDR_W];
    logic [31:0] mem_z [1<<ADDR_W];
    logic [31:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic        wr_en;

    // Configuration
    logic signed [31:0] box_lo_reg [3];
    logic signed [31:0] box_hi_reg [3];
    logic [5:0]         max_iter_reg;

    // Work registers
    logic signed [31:0] pt_reg [3];
    logic [8:0]         idx_reg [3];
    logic signed [31:0] base_reg [3];
    logic signed [32:0] delta_reg [3];
    logic signed [32:0] edge_reg [3];
    logic signed [9:0]  step_reg [3];
    logic [1:0]         axis_reg;
    logic [3:0]         term_reg;
    logic [127:0]       pos_reg, neg_reg, nrm_reg, m_reg, prod_reg;
    logic               negative_reg;
    logic [3:0]         bit_reg;
    logic [8:0]         q_reg;
    logic [5:0]         count_reg;
    logic               box_out_reg;
    out_item_t          res_reg;
    logic               out_valid_reg;

    // Configuration port
    assign pready = 1'b1;
    logic [2:0] reg_sel;
    assign reg_sel = paddr[4:2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= '0;
            end
            max_iter_reg <= 6'(ITER_RESET);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_BOX_X_LOW:  box_lo_reg[0] <= pwdata;
                REG_BOX_X_HIGH: box_hi_reg[0] <= pwdata;
                REG_BOX_Y_LOW:  box_lo_reg[1] <= pwdata;
                REG_BOX_Y_HIGH: box_hi_reg[1] <= pwdata;
                REG_BOX_Z_LOW:  box_lo_reg[2] <= pwdata;
                REG_BOX_Z_HIGH: box_hi_reg[2] <= pwdata;
                REG_MAX_ITER:   max_iter_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BOX_X_LOW:  prdata = box_lo_reg[0];
            REG_BOX_X_HIGH: prdata = box_hi_reg[0];
            REG_BOX_Y_LOW:  prdata = box_lo_reg[1];
            REG_BOX_Y_HIGH: prdata = box_hi_reg[1];
            REG_BOX_Z_LOW:  prdata = box_lo_reg[2];
            REG_BOX_Z_HIGH: prdata = box_hi_reg[2];
            REG_MAX_ITER:   prdata = {26'd0, max_iter_reg};
            default:        prdata = '0;
        endcase
    end

    // Handshake
    logic in_xfer;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    assign wr_en     = in_xfer && (in_data.cmd == CMD_LOAD);

    // Read address: base node, or neighbor along the current axis; load address on a write
    logic [8:0] nb [3];
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            nb[a] = idx_reg[a] + ((state_reg == ST_RDE && axis_reg == 2'(a)) ? 9'd1 : 9'd0);
        if (wr_en)
            rd_addr = {in_data.pos_i, in_data.pos_j, in_data.pos_k};
        else
            rd_addr = {nb[0][4:0], nb[1][4:0], nb[2][4:0]};
    end

    // Node memories: write on load, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[rd_addr] <= in_data.coord_x;
            mem_y[rd_addr] <= in_data.coord_y;
            mem_z[rd_addr] <= in_data.coord_z;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
        rd_z_reg <= mem_z[rd_addr];
    end

    // Shared multiplier: operand magnitudes chosen by term and state
    logic [32:0]  mul_a;
    logic [32:0]  mul_b;
    logic [65:0]  mul_p;
    logic [1:0]   term_ax;
    logic         term_dot;
    logic         term_neg;
    logic [32:0]  ed_mag, dl_mag;
    always_comb
    begin
        term_ax  = 2'(term_reg >> 1);
        term_dot = !term_reg[0];
        ed_mag = edge_reg[term_ax][32] ? 33'(-edge_reg[term_ax]) : 33'(edge_reg[term_ax]);
        dl_mag = delta_reg[term_ax][32] ? 33'(-delta_reg[term_ax]) : 33'(delta_reg[term_ax]);
        term_neg = delta_reg[term_ax][32] != edge_reg[term_ax][32];
        if (state_reg == ST_QMUL)
        begin
            // nrm * candidate, done in four 32-bit chunks of nrm
            mul_a = {1'b0, nrm_reg[32*term_reg[1:0] +: 32]};
            mul_b = {24'd0, q_reg | (9'd1 << bit_reg)};
        end
        else
        begin
            mul_a = ed_mag;
            mul_b = term_dot ? dl_mag : ed_mag;
        end
        mul_p = {33'd0, mul_a} * {33'd0, mul_b};
    end

    logic [9:0]   cand;
    logic [9:0]   nmax;
    logic [127:0] m_diff;
    always_comb
    begin
        cand = {1'b0, q_reg | (9'd1 << bit_reg)};
        unique case (axis_reg)
            2'd0:    nmax = 10'(GRID_N1);
            2'd1:    nmax = 10'(GRID_N2);
            default: nmax = 10'(GRID_N3);
        endcase
        m_diff = (neg_reg > pos_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;
    end

    // Index update and convergence
    logic signed [10:0] sum [3];
    logic [8:0]         new_idx [3];
    logic [10:0]        ctest;
    logic               any_out;
    always_comb
    begin
        ctest = '0;
        any_out = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = 11'(signed'({2'b00, idx_reg[a]})) + 11'(step_reg[a]);
        end
        new_idx[0] = clamp_idx(sum[0], GRID_N1);
        new_idx[1] = clamp_idx(sum[1], GRID_N2);
        new_idx[2] = clamp_idx(sum[2], GRID_N3);
        for (int a = 0; a < 3; a++)
        begin
            ctest = ctest | 11'(step_reg[a]);
        end
        if ((step_reg[0] <= 0 && new_idx[0] == 0) || (step_reg[1] <= 0 && new_idx[1] == 0)
            || (step_reg[2] <= 0 && new_idx[2] == 0))
            any_out = 1'b1;
        if ((step_reg[0] != 0 && new_idx[0] >= 9'(GRID_N1 - 2))
            || (step_reg[1] != 0 && new_idx[1] >= 9'(GRID_N2 - 2))
            || (step_reg[2] != 0 && new_idx[2] >= 9'(GRID_N3 - 2)))
            any_out = 1'b1;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_xfer && in_data.cmd == CMD_LOOKUP) state_next = ST_BOX;
            ST_BOX:   state_next = box_out_reg ? ST_OUT : ST_RDB;
            ST_RDB:   state_next = ST_WB;
            ST_WB:    state_next = ST_RDE;
            ST_RDE:   state_next = ST_WE;
            ST_WE:    state_next = ST_MUL;
            ST_MUL:   if (term_reg == 4'd5) state_next = ST_SIGN;
            ST_SIGN:  state_next = (m_diff == '0 || nrm_reg == '0) ? ST_AXEND : ST_QMUL;
            ST_QMUL:  if (term_reg == 4'd3) state_next = ST_QCMP;
            ST_QCMP:  state_next = (bit_reg == 4'd0) ? ST_AXEND : ST_QMUL;
            ST_AXEND: state_next = (axis_reg == 2'd2) ? ST_UPD : ST_RDE;
            ST_UPD:
            begin
                if (ctest == '0 || (count_reg + 6'd1) >= max_iter_reg)
                    state_next = ST_OUT;
                else
                    state_next = ST_RDB;
            end
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                pt_reg[0] <= in_data.coord_x;
                pt_reg[1] <= in_data.coord_y;
                pt_reg[2] <= in_data.coord_z;
                idx_reg[0] <= clamp_idx(11'(in_data.pos_i), GRID_N1);
                idx_reg[1] <= clamp_idx(11'(in_data.pos_j), GRID_N2);
                idx_reg[2] <= clamp_idx(11'(in_data.pos_k), GRID_N3);
                count_reg <= '0;
                for (int a = 0; a < 3; a++) step_reg[a] <= '0;
                box_out_reg <= (in_data.coord_x < box_lo_reg[0]) ||
                               (in_data.coord_x > box_hi_reg[0]) ||
                               (in_data.coord_y < box_lo_reg[1]) ||
                               (in_data.coord_y > box_hi_reg[1]) ||
                               (in_data.coord_z < box_lo_reg[2]) ||
                               (in_data.coord_z > box_hi_reg[2]);
            end
            ST_BOX:
            begin
                if (box_out_reg)
                    res_reg <= '{status: STATUS_OUTSIDE, default: '0};
                axis_reg <= '0;
            end
            ST_WB:
            begin
                base_reg[0]  <= rd_x_reg;
                base_reg[1]  <= rd_y_reg;
                base_reg[2]  <= rd_z_reg;
                delta_reg[0] <= 33'(pt_reg[0]) - 33'(signed'(rd_x_reg));
                delta_reg[1] <= 33'(pt_reg[1]) - 33'(signed'(rd_y_reg));
                delta_reg[2] <= 33'(pt_reg[2]) - 33'(signed'(rd_z_reg));
                axis_reg <= '0;
            end
            ST_WE:
            begin
                edge_reg[0] <= 33'(signed'(rd_x_reg)) - 33'(base_reg[0]);
                edge_reg[1] <= 33'(signed'(rd_y_reg)) - 33'(base_reg[1]);
                edge_reg[2] <= 33'(signed'(rd_z_reg)) - 33'(base_reg[2]);
                pos_reg  <= '0;
                neg_reg  <= '0;
                nrm_reg  <= '0;
                term_reg <= '0;
            end
            ST_MUL:
            begin
                // accumulate one product per cycle
                if (term_dot)
                begin
                    if (term_neg) neg_reg <= neg_reg + 128'(mul_p);
                    else          pos_reg <= pos_reg + 128'(mul_p);
                end
                else
                    nrm_reg <= nrm_reg + 128'(mul_p);
                term_reg <= (term_reg == 4'd5) ? 4'd0 : term_reg + 4'd1;
            end
            ST_SIGN:
            begin
                negative_reg <= neg_reg > pos_reg;
                m_reg    <= m_diff;
                q_reg    <= (m_diff == '0) ? 9'd0 : ((nrm_reg == '0) ? 9'(nmax) : 9'd0);
                bit_reg  <= 4'd8;
                prod_reg <= '0;
                term_reg <= '0;
            end
            ST_QMUL:
            begin
                prod_reg <= prod_reg + (128'(mul_p) << (32 * term_reg[1:0]));
                term_reg <= (term_reg == 4'd3) ? 4'd0 : term_reg + 4'd1;
            end
            ST_QCMP:
            begin
                if (cand <= nmax && prod_reg <= m_reg)
                    q_reg <= cand[8:0];
                prod_reg <= '0;
                bit_reg <= bit_reg - 4'd1;
            end
            ST_AXEND:
            begin
                if (negative_reg && q_reg != 0)
                    step_reg[axis_reg] <= -10'(signed'({1'b0, q_reg})) - 10'sd1;
                else if (negative_reg)
                    step_reg[axis_reg] <= '0;
                else
                    step_reg[axis_reg] <= 10'(signed'({1'b0, q_reg}));
                axis_reg <= axis_reg + 2'd1;
            end
            ST_UPD:
            begin
                for (int a = 0; a < 3; a++) idx_reg[a] <= new_idx[a];
                count_reg <= count_reg + 6'd1;
                if (ctest == '0)
                    res_reg <= '{status: STATUS_FOUND, cell_i: new_idx[0][4:0],
                                 cell_j: new_idx[1][4:0], cell_k: new_idx[2][4:0]};
                else if (any_out)
                    res_reg <= '{status: STATUS_OUTSIDE, default: '0};
                else
                    res_reg <= '{status: STATUS_NOCONV, default: '0};
            end
            default: ;
        endcase
    end

endmodule

@@ dv/tb_curvilinear_grid_cell_search_unit.sv @@
// Testbench for the curvilinear grid cell search unit: random and directed loads and lookups.
module tb_curvilinear_grid_cell_search_unit;

    import cgcs_pkg::*;

    localparam logic signed [31:0] CMAX = 32'sh7fffffff;
    localparam logic signed [31:0] CMIN = 32'sh80000000;

    // Mirror of the node stores and registers, plus the queue of expected cells
    class grid_scoreboard;
        logic signed [31:0] node_mem [3][32768];
        bit                 written [32768];
        logic signed [31:0] box_lo [3];
        logic signed [31:0] box_hi [3];
        logic [5:0]         iter_lim;
        out_item_t          cell_q [$];
        int                 errors;
        int                 n_loads, n_lookups, n_found, n_outside, n_noconv;

        function new();
            for (int a = 0; a < 3; a++)
            begin
                box_lo[a] = '0;
                box_hi[a] = '0;
            end
            iter_lim = 6'(ITER_RESET);
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_BOX_X_LOW:  box_lo[0] = v;
                REG_BOX_X_HIGH: box_hi[0] = v;
                REG_BOX_Y_LOW:  box_lo[1] = v;
                REG_BOX_Y_HIGH: box_hi[1] = v;
                REG_BOX_Z_LOW:  box_lo[2] = v;
                REG_BOX_Z_HIGH: box_hi[2] = v;
                REG_MAX_ITER:   iter_lim = v[5:0];
                default: ;
            endcase
        endfunction

        function int node_addr(int i, int j, int k);
            return ((i & 31) << 10) | ((j & 31) << 5) | (k & 31);
        endfunction

        // Saturated trunc(dot/norm2), negated and one lower when negative and nonzero
        function int axis_step(longint d [3], longint e [3], int nmax);
            logic signed [127:0] dot, nrm, dd, ee, m, qq;
            int q;
            dot = 0;
            nrm = 0;
            for (int b = 0; b < 3; b++)
            begin
                dd = d[b];
                ee = e[b];
                dot += dd * ee;
                nrm += ee * ee;
            end
            if (dot == 0)
                return 0;
            if (nrm == 0)
                q = nmax;
            else
            begin
                m = (dot < 0) ? -dot : dot;
                qq = m / nrm;
                q = (qq > nmax) ? nmax : int'(qq);
            end
            if (dot < 0 && q > 0)
                q = -q - 1;
            return q;
        endfunction

        function int clamp_cell(int v, int n);
            if (v >= n - 1)
                v = n - 2;
            if (v < 0)
                v = 0;
            return v;
        endfunction

        // Work out the cell a lookup ends in; flag any read of an unloaded node
        function void predict(in_item_t it, output out_item_t r, output bit bad);
            logic signed [31:0] pt [3];
            int     idx [3], stp [3], n [3], sz [3];
            longint base [3], delta [3], edge_v [3];
            int     a0, an, cnt, ctest;
            status_t st;
            bad = 0;
            sz = '{GRID_N1, GRID_N2, GRID_N3};
            idx = '{int'(it.pos_i), int'(it.pos_j), int'(it.pos_k)};
            pt = '{it.coord_x, it.coord_y, it.coord_z};
            stp = '{0, 0, 0};
            st = STATUS_FOUND;
            for (int a = 0; a < 3; a++)
                if (pt[a] < box_lo[a] || pt[a] > box_hi[a])
                    st = STATUS_OUTSIDE;
            if (st == STATUS_FOUND)
            begin
                for (int a = 0; a < 3; a++)
                    idx[a] = clamp_cell(idx[a], sz[a]);
                cnt = 0;
                do
                begin
                    a0 = node_addr(idx[0], idx[1], idx[2]);
                    if (!written[a0])
                        bad = 1;
                    for (int b = 0; b < 3; b++)
                    begin
                        base[b] = node_mem[b][a0];
                        delta[b] = longint'(pt[b]) - base[b];
                    end
                    for (int a = 0; a < 3; a++)
                    begin
                        n = idx;
                        n[a] += 1;
                        an = node_addr(n[0], n[1], n[2]);
                        if (!written[an])
                            bad = 1;
                        for (int b = 0; b < 3; b++)
                            edge_v[b] = longint'(node_mem[b][an]) - base[b];
                        stp[a] = axis_step(delta, edge_v, sz[a]);
                    end
                    ctest = 0;
                    for (int a = 0; a < 3; a++)
                    begin
                        idx[a] = clamp_cell(idx[a] + stp[a], sz[a]);
                        ctest += (stp[a] < 0) ? -stp[a] : stp[a];
                    end
                    cnt++;
                end
                while (ctest > 0 && cnt < int'(iter_lim));
                if (ctest != 0)
                begin
                    st = STATUS_NOCONV;
                    for (int a = 0; a < 3; a++)
                        if ((stp[a] <= 0 && idx[a] == 0) || (stp[a] != 0 && idx[a] >= sz[a] - 2))
                            st = STATUS_OUTSIDE;
                end
            end
            r.status = st;
            r.cell_i = (st == STATUS_FOUND) ? idx[0][4:0] : '0;
            r.cell_j = (st == STATUS_FOUND) ? idx[1][4:0] : '0;
            r.cell_k = (st == STATUS_FOUND) ? idx[2][4:0] : '0;
        endfunction

        // Note an accepted input transfer
        function void note_input(in_item_t it);
            out_item_t r;
            bit        bad;
            int        ad;
            if (it.cmd == CMD_LOAD)
            begin
                ad = node_addr(it.pos_i, it.pos_j, it.pos_k);
                node_mem[0][ad] = it.coord_x;
                node_mem[1][ad] = it.coord_y;
                node_mem[2][ad] = it.coord_z;
                written[ad] = 1;
                n_loads++;
            end
            else
            begin
                predict(it, r, bad);
                cell_q.push_back(r);
                n_lookups++;
                case (r.status)
                    STATUS_FOUND:   n_found++;
                    STATUS_OUTSIDE: n_outside++;
                    default:        n_noconv++;
                endcase
            end
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_result(out_item_t got);
            out_item_t e;
            if (cell_q.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d cell=%0d,%0d,%0d", $time,
                         got.status, got.cell_i, got.cell_j, got.cell_k);
                errors++;
                return;
            end
            e = cell_q.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.cell_i !== e.cell_i)
            begin
                $display("%0t: cell_i expected %0d got %0d", $time, e.cell_i, got.cell_i);
                errors++;
            end
            if (got.cell_j !== e.cell_j)
            begin
                $display("%0t: cell_j expected %0d got %0d", $time, e.cell_j, got.cell_j);
                errors++;
            end
            if (got.cell_k !== e.cell_k)
            begin
                $display("%0t: cell_k expected %0d got %0d", $time, e.cell_k, got.cell_k);
                errors++;
            end
        endfunction

        function int pending();
            return cell_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_scoreboard sb;
    bit             calm;
    bit             hold_arm;

    // Region of regularly spaced nodes used by the current phase
    int     reg_o [3];
    int     reg_b;
    longint reg_s;
    longint reg_base [3];

    curvilinear_grid_cell_search_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // Receive results: random stall, long hold on request, check each transfer
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_data);
            if (hold_arm)
            begin
                hold_arm = 0;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 30) ||
                             (out_stall && $urandom_range(0, 99) < 70);
        end
    end

    // Send one transfer and note it once accepted
    task automatic send_item(in_item_t it);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
    endtask

    task automatic send_load(int i, int j, int k, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z);
        in_item_t it;
        it.cmd = CMD_LOAD;
        it.pos_i = 5'(i);
        it.pos_j = 5'(j);
        it.pos_k = 5'(k);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        send_item(it);
    endtask

    // Send a lookup; turn it into a harmless item if it would read an unloaded node
    task automatic send_lookup(int i, int j, int k, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
        in_item_t  it;
        out_item_t r;
        bit        bad;
        int        ad;
        it.cmd = CMD_LOOKUP;
        it.pos_i = 5'(i);
        it.pos_j = 5'(j);
        it.pos_k = 5'(k);
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        sb.predict(it, r, bad);
        if (bad)
        begin
            if (sb.box_hi[0] != CMAX)
                it.coord_x = sb.box_hi[0] + 1;
            else if (sb.box_lo[0] != CMIN)
                it.coord_x = sb.box_lo[0] - 1;
            else
            begin
                // turn it into a load of the node, with its own value if it was loaded
                ad = sb.node_addr(i, j, k);
                it.cmd = CMD_LOAD;
                if (sb.written[ad])
                begin
                    it.coord_x = sb.node_mem[0][ad];
                    it.coord_y = sb.node_mem[1][ad];
                    it.coord_z = sb.node_mem[2][ad];
                end
            end
        end
        send_item(it);
    endtask

    // Write one register: setup phase, then access phase
    task automatic reg_write(reg_idx_t r, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic write_box(logic signed [31:0] lo [3], logic signed [31:0] hi [3],
                             logic [5:0] iters);
        reg_write(REG_BOX_X_LOW, lo[0]);
        reg_write(REG_BOX_X_HIGH, hi[0]);
        reg_write(REG_BOX_Y_LOW, lo[1]);
        reg_write(REG_BOX_Y_HIGH, hi[1]);
        reg_write(REG_BOX_Z_LOW, lo[2]);
        reg_write(REG_BOX_Z_HIGH, hi[2]);
        reg_write(REG_MAX_ITER, 32'(iters));
    endtask

    // Drop valid and wait until every expected cell has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function logic signed [31:0] region_coord(int a, int t);
        longint jit;
        jit = longint'($urandom_range(0, 32'(reg_s / 4))) - reg_s / 8;
        return 32'(reg_base[a] + longint'(reg_o[a] + t) * reg_s + jit);
    endfunction

    function logic signed [31:0] region_point(int a);
        return 32'(reg_base[a] + longint'(reg_o[a]) * reg_s +
                   longint'($urandom_range(0, 32'(reg_b * reg_s))) - reg_s / 16);
    endfunction

    // Extremes, both corners of the index range, and a zero edge
    task automatic directed();
        logic signed [31:0] lo [3], hi [3];
        lo = '{CMIN, CMIN, CMIN};
        hi = '{CMAX, CMAX, CMAX};
        write_box(lo, hi, 6'd50);
        for (int i = 30; i < 32; i++)
            for (int j = 30; j < 32; j++)
                for (int k = 30; k < 32; k++)
                    send_load(i, j, k, (i == 31) ? CMAX : CMIN, (j == 31) ? CMAX : CMIN,
                              (k == 31) ? CMAX : CMIN);
        send_lookup(31, 31, 31, 0, 0, 0);
        send_lookup(31, 31, 31, CMAX, CMAX, CMAX);
        send_lookup(30, 30, 30, CMIN, CMIN, CMIN);
        // zero edge along the first axis
        send_load(31, 30, 30, CMIN, CMIN, CMIN);
        send_lookup(30, 30, 30, 0, 0, 0);
        send_lookup(30, 30, 30, CMIN, CMIN, CMIN);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                for (int k = 0; k < 2; k++)
                    send_load(i, j, k, 32'(i * 65536), 32'(j * 65536), 32'(k * 65536));
        send_lookup(0, 0, 0, 32768, 32768, 32768);
        send_lookup(0, 0, 0, -1, -1, -1);
        send_lookup(0, 0, 0, 65536, 65536, 65536);
    endtask

    // One phase: pick a region and settings, load the region, then look up points
    task automatic run_phase(int p);
        logic signed [31:0] lo [3], hi [3];
        logic [5:0] iters;
        int r;
        reg_b = $urandom_range(1, 3);
        reg_s = longint'(1) << $urandom_range(10, 20);
        for (int a = 0; a < 3; a++)
        begin
            reg_o[a] = (p == 6) ? 31 - reg_b : $urandom_range(0, 31 - reg_b);
            reg_base[a] = longint'($urandom_range(0, 32'h20000000)) - 64'h10000000;
            lo[a] = CMIN;
            hi[a] = CMAX;
        end
        case (p)
            1, 5:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lo[a] = 32'(reg_base[a] + longint'(reg_o[a]) * reg_s - reg_s / 4);
                    hi[a] = 32'(reg_base[a] + longint'(reg_o[a] + reg_b) * reg_s + reg_s / 4);
                end
                iters = (p == 1) ? 6'd1 : 6'd2;
            end
            2:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    lo[a] = $urandom;
                    hi[a] = $urandom;
                end
                iters = $urandom_range(1, 63);
            end
            3:
            begin
                lo = '{CMAX, CMAX, CMAX};
                hi = '{CMIN, CMIN, CMIN};
                iters = 6'd0;
            end
            0:       iters = 6'd63;
            4:       iters = 6'd50;
            default: iters = $urandom_range(1, 63);
        endcase
        write_box(lo, hi, iters);
        calm = (p == 4);
        for (int i = 0; i <= reg_b; i++)
            for (int j = 0; j <= reg_b; j++)
                for (int k = 0; k <= reg_b; k++)
                    send_load(reg_o[0] + i, reg_o[1] + j, reg_o[2] + k, region_coord(0, i),
                              region_coord(1, j), region_coord(2, k));
        for (int n = 0; n < 60; n++)
        begin
            if (p == 4 && n == 20)
                hold_arm = 1;
            if (p == 2 && n == 30)
            begin
                in_valid <= 1'b0;
                while (sb.pending() > 0)
                    @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 75)
                send_lookup(reg_o[0] + $urandom_range(0, reg_b), reg_o[1] + $urandom_range(0, reg_b),
                            reg_o[2] + $urandom_range(0, reg_b), region_point(0), region_point(1),
                            region_point(2));
            else if (r < 85)
                send_lookup($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                            region_point(0), region_point(1), region_point(2));
            else if (r < 95)
                send_lookup($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                            $urandom, $urandom, $urandom);
            else
                send_load($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom, $urandom, $urandom);
        end
    endtask

    // Overall run limit
    initial
    begin
        #1000000000;
        $display("tb_curvilinear_grid_cell_search_unit: FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 0;
        hold_arm = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int p = 0; p < 7; p++)
        begin
            drain();
            run_phase(p);
        end
        drain();
        $display("Covered %0d loads and %0d lookups over seven box and iteration settings.",
                 sb.n_loads, sb.n_lookups);
        $display("Lookups ended found %0d, outside %0d, not converged %0d; mismatches %0d.",
                 sb.n_found, sb.n_outside, sb.n_noconv, sb.errors);
        if (sb.errors == 0)
            $display("tb_curvilinear_grid_cell_search_unit: PASS");
        else
            $display("tb_curvilinear_grid_cell_search_unit: FAIL");
        $finish;
    end

endmodule
